>>> rtl/slac_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// slac_pkg
// shared types, codes and default sizes of the set-associative block cache
// ----------------------------------------------------------------------------
package slac_pkg;

  // default geometry (counts must be powers of two)
  localparam int WAYS_DEF        = 16;
  localparam int SETS_DEF        = 2;
  localparam int SET_SPAN_DEF    = 4;
  localparam int LINE_BYTES_DEF  = 128;
  localparam int TAG_SHIFT_DEF   = 7;
  localparam int STAMP_WIDTH_DEF = 32;

  // fixed field widths
  localparam int ADDR_W     = 32;
  localparam int BLK_W      = 28;
  localparam int BLK_SHIFT  = 4;
  localparam int SLOT_W     = 3;
  localparam int WORD_BITS  = 64;
  localparam int WORD_W     = 4;
  localparam int LINE_WORDS = 16;
  localparam int PE_W       = 8;
  localparam int COUNT_W    = 32;

  localparam int IN_TDATA_W  = 168;
  localparam int OUT_TDATA_W = 144;

  typedef logic [1:0] op_t;
  localparam op_t OP_FIRST_READ = 2'd0;
  localparam op_t OP_READ       = 2'd1;
  localparam op_t OP_WRITE      = 2'd2;
  localparam op_t OP_NONE       = 2'd3;

  typedef logic [1:0] resp_t;
  localparam resp_t RSP_DATA       = 2'd0;
  localparam resp_t RSP_FIRST_HIT  = 2'd1;
  localparam resp_t RSP_FIRST_MISS = 2'd2;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ADDR,
    ST_SCAN,
    ST_WR_LO,
    ST_WR_HI,
    ST_EMIT,
    ST_MISS_RSP
  } state_t;

  // way scan status toward the sequencer
  typedef struct packed {
    logic done;
    logic hit;
  } scan_status_t;

endpackage : slac_pkg
`default_nettype wire

>>> rtl/set_assoc_lru_block_cache_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// set_assoc_lru_block_cache_core
// set-associative block cache with lru replacement by use stamps
// ----------------------------------------------------------------------------
// after reset a clearing pass over all SETS*WAYS*16 line words zeroes the
// line, tag and stamp rams; no beat is taken meanwhile
// per request: an address state, a way scan (one way a cycle through the
// shared compare unit), then for a read or first-read hit 16 line beats at
// one per cycle from the line ram read port unless the output stalls; a write
// stores its low and high words, a first-read miss sends one wordless beat;
// the input is ready only when idle
module set_assoc_lru_block_cache_core #(
  parameter int WAYS        = slac_pkg::WAYS_DEF,
  parameter int SETS        = slac_pkg::SETS_DEF,
  parameter int SET_SPAN    = slac_pkg::SET_SPAN_DEF,
  parameter int LINE_BYTES  = slac_pkg::LINE_BYTES_DEF,
  parameter int TAG_SHIFT   = slac_pkg::TAG_SHIFT_DEF,
  parameter int STAMP_WIDTH = slac_pkg::STAMP_WIDTH_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  // configuration: base_address
  input  wire logic                                cfg_wr_en,
  input  wire logic [slac_pkg::ADDR_W-1:0]         cfg_wr_data,
  // request stream
  input  wire logic                                s_axis_tvalid,
  output logic                                     s_axis_tready,
  // block_id, write_slot, write_low, write_high, pe_tag, array_tag
  input  wire logic [slac_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  // op
  input  wire logic [1:0]                          s_axis_tuser,
  // response stream
  output logic                                     m_axis_tvalid,
  input  wire logic                                m_axis_tready,
  // word_index, line_word, pe_out, array_out, access_count, hit_count, 3 pad
  output logic      [slac_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
  // response, has_word
  output logic      [2:0]                          m_axis_tuser,
  // last
  output logic                                     m_axis_tlast
);
  import slac_pkg::*;

  // geometry
  localparam int WAY_W      = $clog2(WAYS);
  localparam int SET_W      = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int ENTRIES    = SETS * WAYS;
  localparam int ENT_W      = $clog2(ENTRIES);
  localparam int LA_W       = ENT_W + WORD_W;
  localparam int LINE_DEPTH = ENTRIES * LINE_WORDS;
  localparam int TAG_W      = ADDR_W - TAG_SHIFT;
  localparam int WAY_DATA_W = TAG_W + STAMP_WIDTH;
  // set bits sit above the line offset and the span bits
  localparam int SET_LSB    = $clog2(LINE_BYTES) + $clog2(SET_SPAN);

  localparam logic [ENT_W-1:0]  WAYS_E    = ENT_W'(WAYS);
  localparam logic [LA_W-1:0]   CLR_LAST  = LA_W'(LINE_DEPTH - 1);
  localparam logic [WORD_W-1:0] LAST_WORD = WORD_W'(LINE_WORDS - 1);

  // control state
  state_t                 state, state_next;
  logic [LA_W-1:0]        clr_cnt;
  logic [ADDR_W-1:0]      base_address;
  logic [STAMP_WIDTH-1:0] request_stamp;
  logic [COUNT_W-1:0]     access_total;
  logic [COUNT_W-1:0]     hit_total;

  // latched request
  op_t                    op_q;
  logic [BLK_W-1:0]       blk_q;
  logic [SLOT_W-1:0]      slot_q;
  logic [WORD_BITS-1:0]   wlo_q, whi_q;
  logic [PE_W-1:0]        pe_q;
  logic                   arr_q;
  logic [SET_W-1:0]       set_q;
  logic [TAG_W-1:0]       tag_q;
  logic [ENT_W-1:0]       ent_q;
  resp_t                  resp_q;
  logic                   zero_line;

  // beat issue: iss_idx counts to 16, pend marks a word waiting in ram rdata
  logic [WORD_W:0]        iss_idx;
  logic                   pend;
  logic [WORD_W-1:0]      pend_idx;

  // output register
  logic                   out_valid;
  resp_t                  out_resp;
  logic                   out_has;
  logic [WORD_W-1:0]      out_idx;
  logic [WORD_BITS-1:0]   out_word;
  logic [PE_W-1:0]        out_pe;
  logic                   out_arr;
  logic [COUNT_W-1:0]     out_acc;
  logic [COUNT_W-1:0]     out_hits;
  logic                   out_last;
  logic                   out_free;

  // scan unit
  scan_status_t           scan_st;
  logic                   scan_start;
  logic                   scan_rd_en;
  logic [WAY_W-1:0]       scan_way;
  logic [WAY_W-1:0]       hit_way, victim_way, way_sel;
  logic [ENT_W-1:0]       ent_sel, ent_rd;

  // ram ports
  logic                   way_we;
  logic [ENT_W-1:0]       way_waddr;
  logic [WAY_DATA_W-1:0]  way_wdata, way_rdata;
  logic                   line_we;
  logic [LA_W-1:0]        line_waddr;
  logic [WORD_BITS-1:0]   line_wdata, line_rdata;

  logic                   in_fire, decide, issue, load, single_load;
  logic [ADDR_W-1:0]      addr_sum;

  assign in_fire  = s_axis_tready && s_axis_tvalid;
  assign out_free = !out_valid || m_axis_tready;

  // byte address of the block and entry numbers of the set
  assign addr_sum = base_address + {blk_q, {BLK_SHIFT{1'b0}}};
  assign way_sel  = scan_st.hit ? hit_way : victim_way;
  assign ent_sel  = ENT_W'(set_q) * WAYS_E + ENT_W'(way_sel);
  assign ent_rd   = ENT_W'(set_q) * WAYS_E + ENT_W'(scan_way);

  // ports
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {3'b000, out_hits, out_acc, out_arr, out_pe, out_word, out_idx};
  assign m_axis_tuser  = {out_has, out_resp};
  assign m_axis_tlast  = out_last;

  // way store: tag above stamp, one entry per way of each set
  slac_ram #(
    .WIDTH (WAY_DATA_W),
    .DEPTH (ENTRIES)
  ) u_way_ram (
    .clk   (clk),
    .we    (way_we),
    .waddr (way_waddr),
    .wdata (way_wdata),
    .re    (scan_rd_en),
    .raddr (ent_rd),
    .rdata (way_rdata)
  );

  // line store: 16 words per entry
  slac_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (LINE_DEPTH)
  ) u_line_ram (
    .clk   (clk),
    .we    (line_we),
    .waddr (line_waddr),
    .wdata (line_wdata),
    .re    (issue),
    .raddr ({ent_q, iss_idx[WORD_W-1:0]}),
    .rdata (line_rdata)
  );

  slac_way_scan #(
    .WAYS    (WAYS),
    .TAG_W   (TAG_W),
    .STAMP_W (STAMP_WIDTH)
  ) u_scan (
    .clk        (clk),
    .rst        (rst),
    .start      (scan_start),
    .tag        (tag_q),
    .rd_tag     (way_rdata[STAMP_WIDTH +: TAG_W]),
    .rd_stamp   (way_rdata[STAMP_WIDTH-1:0]),
    .rd_en      (scan_rd_en),
    .rd_way     (scan_way),
    .status     (scan_st),
    .hit_way    (hit_way),
    .victim_way (victim_way)
  );

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // sequencer: next state and ram/beat strobes
  always_comb begin
    state_next    = state;
    s_axis_tready = 1'b0;
    scan_start    = 1'b0;
    decide        = 1'b0;
    way_we        = 1'b0;
    way_waddr     = ent_sel;
    way_wdata     = {tag_q, request_stamp};
    line_we       = 1'b0;
    line_waddr    = {ent_q, iss_idx[WORD_W-1:0]};
    line_wdata    = '0;
    issue         = 1'b0;
    load          = 1'b0;
    single_load   = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        line_we    = 1'b1;
        line_waddr = clr_cnt;
        way_we     = 1'b1;
        way_waddr  = clr_cnt[LA_W-1:WORD_W];
        way_wdata  = '0;
        if (clr_cnt == CLR_LAST) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        // unused op code is taken and dropped
        if (s_axis_tvalid && s_axis_tuser != OP_NONE) begin
          state_next = ST_ADDR;
        end
      end
      ST_ADDR: begin
        scan_start = 1'b1;
        state_next = ST_SCAN;
      end
      ST_SCAN: begin
        if (scan_st.done) begin
          decide = 1'b1;
          if (scan_st.hit || op_q != OP_FIRST_READ) begin
            // hit keeps its tag; a miss installs it over the victim
            way_we     = 1'b1;
            state_next = (op_q == OP_WRITE) ? ST_WR_LO : ST_EMIT;
          end else begin
            state_next = ST_MISS_RSP;
          end
        end
      end
      ST_WR_LO: begin
        line_we    = 1'b1;
        line_waddr = {ent_q, slot_q, 1'b0};
        line_wdata = wlo_q;
        state_next = ST_WR_HI;
      end
      ST_WR_HI: begin
        line_we    = 1'b1;
        line_waddr = {ent_q, slot_q, 1'b1};
        line_wdata = whi_q;
        state_next = ST_IDLE;
      end
      ST_EMIT: begin
        load  = pend && out_free;
        issue = !iss_idx[WORD_W] && (!pend || load);
        // read miss: zero each word as it goes out
        if (issue && zero_line) begin
          line_we = 1'b1;
        end
        if (load && pend_idx == LAST_WORD) begin
          state_next = ST_IDLE;
        end
      end
      ST_MISS_RSP: begin
        if (out_free) begin
          single_load = 1'b1;
          state_next  = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt       <= '0;
      base_address  <= '0;
      request_stamp <= '0;
      access_total  <= '0;
      hit_total     <= '0;
      iss_idx       <= '0;
      pend          <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        base_address <= cfg_wr_data;
      end
      if (state == ST_CLEAR) begin
        clr_cnt <= clr_cnt + 1'b1;
      end
      if (decide) begin
        request_stamp <= request_stamp + 1'b1;
        if (op_q != OP_WRITE) begin
          access_total <= access_total + 1'b1;
          if (scan_st.hit) begin
            hit_total <= hit_total + 1'b1;
          end
        end
        iss_idx <= '0;
        pend    <= 1'b0;
      end else if (issue) begin
        iss_idx <= iss_idx + 1'b1;
        pend    <= 1'b1;
      end else if (load) begin
        pend <= 1'b0;
      end
      if (load || single_load) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // request and beat payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_q  <= s_axis_tuser;
      blk_q <= s_axis_tdata[27:0];
      slot_q <= s_axis_tdata[30:28];
      wlo_q <= s_axis_tdata[94:31];
      whi_q <= s_axis_tdata[158:95];
      pe_q  <= s_axis_tdata[166:159];
      arr_q <= s_axis_tdata[167];
    end
    if (state == ST_ADDR) begin
      set_q <= (SETS > 1) ? addr_sum[SET_LSB +: SET_W] : '0;
      tag_q <= addr_sum[ADDR_W-1:TAG_SHIFT];
    end
    if (decide) begin
      ent_q     <= ent_sel;
      resp_q    <= (op_q == OP_FIRST_READ) ? RSP_FIRST_HIT : RSP_DATA;
      zero_line <= !scan_st.hit;
      // write miss fills slot 0
      if (!scan_st.hit) begin
        slot_q <= '0;
      end
    end
    if (issue) begin
      pend_idx <= iss_idx[WORD_W-1:0];
    end
    if (load) begin
      out_resp <= resp_q;
      out_has  <= 1'b1;
      out_idx  <= pend_idx;
      out_word <= zero_line ? '0 : line_rdata;
      out_pe   <= pe_q;
      out_arr  <= arr_q;
      out_acc  <= access_total;
      out_hits <= hit_total;
      out_last <= (pend_idx == LAST_WORD);
    end else if (single_load) begin
      out_resp <= RSP_FIRST_MISS;
      out_has  <= 1'b0;
      out_idx  <= '0;
      out_word <= '0;
      out_pe   <= pe_q;
      out_arr  <= arr_q;
      out_acc  <= access_total;
      out_hits <= hit_total;
      out_last <= 1'b1;
    end
  end

  // checks
  a_scan_done_in_scan: assert property (@(posedge clk) disable iff (rst)
    scan_st.done |-> state == ST_SCAN)
    else $error("scan done outside scan state");

  a_pend_in_emit: assert property (@(posedge clk) disable iff (rst)
    pend |-> state == ST_EMIT)
    else $error("line word pending outside emit");

  a_stamp_step: assert property (@(posedge clk) disable iff (rst)
    decide |=> request_stamp == STAMP_WIDTH'($past(request_stamp) + 1'b1))
    else $error("request stamp did not advance by one");

  a_miss_beat_last: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tuser[2]) |-> m_axis_tlast)
    else $error("wordless beat is not the last of its request");

endmodule : set_assoc_lru_block_cache_core
`default_nettype wire

>>> rtl/slac_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// slac_ram
// generic simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module slac_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 512
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule : slac_ram
`default_nettype wire

>>> rtl/slac_way_scan.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// slac_way_scan
// one shared tag/stamp compare unit stepped over the ways of a set
// ----------------------------------------------------------------------------
module slac_way_scan #(
  parameter int WAYS    = 16,
  parameter int TAG_W   = 25,
  parameter int STAMP_W = 32
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  input  wire logic [TAG_W-1:0]            tag,
  input  wire logic [TAG_W-1:0]            rd_tag,
  input  wire logic [STAMP_W-1:0]          rd_stamp,
  output logic                             rd_en,
  output logic      [$clog2(WAYS)-1:0]     rd_way,
  output slac_pkg::scan_status_t           status,
  output logic      [$clog2(WAYS)-1:0]     hit_way,
  output logic      [$clog2(WAYS)-1:0]     victim_way
);
  import slac_pkg::*;

  localparam int WAY_W = $clog2(WAYS);
  localparam logic [WAY_W-1:0] LAST_WAY = WAY_W'(WAYS - 1);

  logic               active;
  logic [WAY_W-1:0]   iss;
  logic               cmp_vld;
  logic [WAY_W-1:0]   cmp_way;
  logic               hit;
  logic               done;
  logic [STAMP_W-1:0] best;

  assign rd_en  = active;
  assign rd_way = iss;
  assign status = '{done: done, hit: hit};

  always_ff @(posedge clk) begin
    if (rst) begin
      active  <= 1'b0;
      cmp_vld <= 1'b0;
      done    <= 1'b0;
      hit     <= 1'b0;
      iss     <= '0;
    end else begin
      done    <= 1'b0;
      cmp_vld <= 1'b0;
      if (start) begin
        active <= 1'b1;
        iss    <= '0;
        hit    <= 1'b0;
      end else if (active) begin
        cmp_vld <= 1'b1;
        if (iss == LAST_WAY) begin
          active <= 1'b0;
        end else begin
          iss <= iss + 1'b1;
        end
      end
      // ram data for cmp_way is present now
      if (cmp_vld) begin
        if (rd_tag == tag) begin
          hit <= 1'b1;
        end
        if (cmp_way == LAST_WAY) begin
          done <= 1'b1;
        end
      end
    end
  end

  // payload side of the compare unit
  always_ff @(posedge clk) begin
    if (active && !start) begin
      cmp_way <= iss;
    end
    if (cmp_vld) begin
      // later matches win: highest matching way
      if (rd_tag == tag) begin
        hit_way <= cmp_way;
      end
      // strict less keeps the lowest way on a tie
      if (cmp_way == '0 || rd_stamp < best) begin
        best       <= rd_stamp;
        victim_way <= cmp_way;
      end
    end
  end

endmodule : slac_way_scan
`default_nettype wire

>>> dv/slac_line_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slac_line_checker
// watches config writes and both streams, keeps its own copy of the cache
// and compares every response beat against the predicted line beats
// ----------------------------------------------------------------------------
module slac_line_checker (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_wr_en,
  input  logic [slac_pkg::ADDR_W-1:0]      cfg_wr_data,
  input  logic                             s_axis_tvalid,
  input  logic                             s_axis_tready,
  // block_id, write_slot, write_low, write_high, pe_tag, array_tag
  input  logic [slac_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  // op
  input  logic [1:0]                       s_axis_tuser,
  input  logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // word_index, line_word, pe_out, array_out, access_count, hit_count, pad
  input  logic [slac_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  // response, has_word
  input  logic [2:0]                       m_axis_tuser,
  input  logic                             m_axis_tlast,
  output int                               fail_count,
  output int                               beats_due
);
  import slac_pkg::*;

  localparam int NWAYS  = WAYS_DEF;
  localparam int NSETS  = SETS_DEF;
  localparam int NLINES = NSETS * NWAYS;
  localparam int TAG_W  = ADDR_W - TAG_SHIFT_DEF;
  localparam int STMP_W = STAMP_WIDTH_DEF;

  typedef struct {
    resp_t                resp;
    logic                 has_word;
    logic [WORD_W-1:0]    word_index;
    logic [WORD_BITS-1:0] line_word;
    logic [PE_W-1:0]      pe;
    logic                 array_sel;
    logic [COUNT_W-1:0]   accesses;
    logic [COUNT_W-1:0]   hits;
    logic                 last;
  } line_beat_t;

  line_beat_t           line_beats_due[$];
  logic [ADDR_W-1:0]    base_address;
  logic [TAG_W-1:0]     tag_ram [NLINES];
  logic [WORD_BITS-1:0] line_ram [NLINES][LINE_WORDS];
  logic [STMP_W-1:0]    stamp_ram [NLINES];
  logic [STMP_W-1:0]    next_stamp;
  logic [COUNT_W-1:0]   access_total;
  logic [COUNT_W-1:0]   hit_total;
  int                   err_n;

  function automatic void queue_line(int row, resp_t resp, logic [PE_W-1:0] pe, logic arr);
    line_beat_t b;
    for (int w = 0; w < LINE_WORDS; w++) begin
      b.resp       = resp;
      b.has_word   = 1'b1;
      b.word_index = WORD_W'(w);
      b.line_word  = line_ram[row][w];
      b.pe         = pe;
      b.array_sel  = arr;
      b.accesses   = access_total;
      b.hits       = hit_total;
      b.last       = (w == LINE_WORDS - 1);
      line_beats_due.push_back(b);
    end
  endfunction

  // one request against the shadow cache, queues the beats it returns
  function automatic void cache_access(op_t op, logic [BLK_W-1:0] blk,
                                       logic [SLOT_W-1:0] slot,
                                       logic [WORD_BITS-1:0] lo, logic [WORD_BITS-1:0] hi,
                                       logic [PE_W-1:0] pe, logic arr);
    logic [ADDR_W-1:0] addr;
    logic [TAG_W-1:0]  tag;
    logic [STMP_W-1:0] oldest;
    int                set_n;
    int                row;
    int                way;
    logic              hit;
    line_beat_t        b;
    if (op == OP_NONE) return;
    addr  = base_address + {blk, 4'b0000};
    set_n = int'(((addr / LINE_BYTES_DEF) % (NSETS * SET_SPAN_DEF)) / SET_SPAN_DEF);
    if (set_n >= NSETS) set_n = 0;
    tag = TAG_W'(addr >> TAG_SHIFT_DEF);
    row = set_n * NWAYS;
    hit = 1'b0;
    way = 0;
    // highest matching way wins, no valid bits
    for (int w = 0; w < NWAYS; w++) begin
      if (tag_ram[row + w] == tag) begin
        way = w;
        hit = 1'b1;
      end
    end
    // victim: least stamp, lowest way on a tie
    if (!hit && op != OP_FIRST_READ) begin
      oldest = stamp_ram[row];
      for (int w = 1; w < NWAYS; w++) begin
        if (stamp_ram[row + w] < oldest) begin
          oldest = stamp_ram[row + w];
          way    = w;
        end
      end
    end
    row = row + way;
    if (hit) begin
      if (op != OP_WRITE) begin
        access_total = access_total + 1'b1;
        hit_total    = hit_total + 1'b1;
        queue_line(row, (op == OP_FIRST_READ) ? RSP_FIRST_HIT : RSP_DATA, pe, arr);
      end else begin
        line_ram[row][{slot, 1'b0}] = lo;
        line_ram[row][{slot, 1'b1}] = hi;
      end
      stamp_ram[row] = next_stamp;
    end else if (op == OP_FIRST_READ) begin
      access_total = access_total + 1'b1;
      b = '{RSP_FIRST_MISS, 1'b0, '0, '0, pe, arr, access_total, hit_total, 1'b1};
      line_beats_due.push_back(b);
    end else if (op == OP_READ) begin
      access_total = access_total + 1'b1;
      for (int w = 0; w < LINE_WORDS; w++) line_ram[row][w] = '0;
      tag_ram[row]   = tag;
      stamp_ram[row] = next_stamp;
      queue_line(row, RSP_DATA, pe, arr);
    end else begin
      line_ram[row][0] = lo;
      line_ram[row][1] = hi;
      tag_ram[row]     = tag;
      stamp_ram[row]   = next_stamp;
    end
    next_stamp = next_stamp + 1'b1;
  endfunction

  function automatic void check_field(string what, logic [WORD_BITS-1:0] want_v,
                                      logic [WORD_BITS-1:0] got_v);
    if (want_v !== got_v) begin
      $display("%0t %s mismatch: expected %0h, got %0h", $time, what, want_v, got_v);
      err_n++;
    end
  endfunction

  always @(posedge clk) begin : monitor
    line_beat_t want;
    if (rst) begin
      base_address = '0;
      next_stamp   = '0;
      access_total = '0;
      hit_total    = '0;
      for (int i = 0; i < NLINES; i++) begin
        tag_ram[i]   = '0;
        stamp_ram[i] = '0;
        for (int w = 0; w < LINE_WORDS; w++) line_ram[i][w] = '0;
      end
      line_beats_due.delete();
    end else begin
      if (cfg_wr_en) base_address = cfg_wr_data;
      if (s_axis_tvalid && s_axis_tready) begin
        cache_access(op_t'(s_axis_tuser), s_axis_tdata[27:0], s_axis_tdata[30:28],
                     s_axis_tdata[94:31], s_axis_tdata[158:95], s_axis_tdata[166:159],
                     s_axis_tdata[167]);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (line_beats_due.size() == 0) begin
          $display("%0t response beat with nothing expected: %h", $time, m_axis_tdata);
          err_n++;
        end else begin
          want = line_beats_due.pop_front();
          check_field("response", want.resp, m_axis_tuser[1:0]);
          check_field("has_word", want.has_word, m_axis_tuser[2]);
          check_field("word_index", want.word_index, m_axis_tdata[3:0]);
          check_field("line_word", want.line_word, m_axis_tdata[67:4]);
          check_field("pe_out", want.pe, m_axis_tdata[75:68]);
          check_field("array_out", want.array_sel, m_axis_tdata[76]);
          check_field("access_count", want.accesses, m_axis_tdata[108:77]);
          check_field("hit_count", want.hits, m_axis_tdata[140:109]);
          check_field("last", want.last, m_axis_tlast);
        end
      end
    end
    fail_count <= err_n;
    beats_due  <= line_beats_due.size();
  end

endmodule

>>> dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// drives requests into the block cache core under several base addresses and
// flow-control mixes; the line checker predicts and compares every beat
// ----------------------------------------------------------------------------
module tb_top;
  import slac_pkg::*;

  // longest legal quiet stretch is the clearing pass after reset;
  // random gaps and stalls stay far below this limit
  localparam int QUIET_LIMIT   = 4000;
  // a write gives no beat but keeps the core busy through its scan and line writes
  localparam int SETTLE_CYCLES = 64;
  localparam int HOT_LINES     = 40;
  localparam int HOT_W         = BLK_W - 3;

  logic                   clk            = 1'b0;
  logic                   rst            = 1'b1;
  logic                   cfg_wr_en      = 1'b0;
  logic [ADDR_W-1:0]      cfg_wr_data    = '0;
  logic                   s_axis_tvalid  = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata   = '0;
  logic [1:0]             s_axis_tuser   = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready  = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic [2:0]             m_axis_tuser;
  logic                   m_axis_tlast;

  int                     fail_count;
  int                     beats_due;
  int                     send_idle_pct  = 0;
  int                     recv_stall_pct = 0;
  int unsigned            quiet_cycles   = 0;
  // working set of line positions, reused so that hits and evictions happen
  logic [HOT_W-1:0]       hot_line [HOT_LINES];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  set_assoc_lru_block_cache_core u_top (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  slac_line_checker u_chk (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .fail_count    (fail_count),
    .beats_due     (beats_due)
  );

  // response side back-pressure, redrawn every cycle
  always @(posedge clk) begin
    m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // watchdog: cycles with no beat taken on either side
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // present one request and hold it until the core takes it; valid stays
  // high afterwards so back-to-back beats need no toggle
  task automatic send_req(input op_t op, input logic [BLK_W-1:0] blk,
                          input logic [SLOT_W-1:0] slot,
                          input logic [WORD_BITS-1:0] lo, input logic [WORD_BITS-1:0] hi,
                          input logic [PE_W-1:0] pe, input logic arr);
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    // tdata from bit 0: block_id, write_slot, write_low, write_high, pe_tag, array_tag
    s_axis_tdata  <= {arr, pe, hi, lo, slot, blk};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
  endtask

  // drop valid, wait for every predicted beat, then let a trailing write finish
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (beats_due != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // new base address, new flow-control mix, mostly working-set traffic
  task automatic run_phase(input logic [ADDR_W-1:0] base, input int idle_pct,
                           input int stall_pct, input int items);
    op_t              op;
    logic [BLK_W-1:0] blk;
    int               pick;
    int               done_n;
    drain();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= base;
    @(posedge clk);
    cfg_wr_en      <= 1'b0;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    for (int i = 0; i < HOT_LINES; i++) hot_line[i] = HOT_W'($urandom);
    done_n = 0;
    while (done_n < items) begin
      pick = $urandom_range(99);
      // a few unused ops as noise, they do not count
      op = (pick < 5) ? OP_NONE : op_t'($urandom_range(int'(OP_WRITE)));
      if (pick >= 5 && pick < 15)
        blk = BLK_W'($urandom);
      else
        blk = {hot_line[$urandom_range($urandom_range(HOT_LINES - 1))], 3'($urandom)};
      send_req(op, blk, SLOT_W'($urandom), {$urandom, $urandom}, {$urandom, $urandom},
               PE_W'($urandom), 1'($urandom));
      if (op != OP_NONE) begin
        done_n++;
        // sender holds off midway until the core has answered everything
        if (done_n == items / 2) drain();
      end
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // directed part at the reset base of zero: every tag reads zero, so
    // addresses below one line hit, and the highest way is the one used
    send_req(OP_FIRST_READ, 28'd0, 3'd0, '0, '0, 8'h00, 1'b0);
    send_req(OP_READ, 28'd7, 3'd0, '0, '0, 8'hFF, 1'b1);
    send_req(OP_WRITE, 28'd0, 3'd7, '1, '1, 8'h5A, 1'b0);
    send_req(OP_WRITE, 28'd3, 3'd0, 64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210,
             8'hA5, 1'b1);
    send_req(OP_READ, 28'd0, 3'd0, '0, '0, 8'h01, 1'b0);
    // unused op with every bit set is dropped without a trace
    send_req(OP_NONE, '1, '1, '1, '1, 8'hFF, 1'b1);
    // first read miss twice: no fill in between
    send_req(OP_FIRST_READ, 28'd8, 3'd0, '0, '0, 8'h80, 1'b1);
    send_req(OP_FIRST_READ, 28'd8, 3'd0, '0, '0, 8'h7F, 1'b0);
    // read miss installs a zero line in the oldest way, lowest index on a tie
    send_req(OP_READ, 28'd8, 3'd0, '0, '0, 8'h10, 1'b0);
    send_req(OP_FIRST_READ, 28'd8, 3'd0, '0, '0, 8'h11, 1'b1);
    // write miss at the top block fills slot 0, not the named slot
    send_req(OP_WRITE, '1, 3'd3, '1, '0, 8'h22, 1'b0);
    send_req(OP_READ, '1, 3'd0, '0, '0, 8'h33, 1'b1);
    send_req(OP_WRITE, 28'd32, 3'd5, {$urandom, $urandom}, {$urandom, $urandom}, 8'h44, 1'b0);
    send_req(OP_WRITE, 28'd32, 3'd2, {$urandom, $urandom}, {$urandom, $urandom}, 8'h55, 1'b1);
    send_req(OP_FIRST_READ, 28'd32, 3'd0, '0, '0, 8'h66, 1'b0);
    send_req(OP_READ, 28'd16, 3'd0, '0, '0, 8'h77, 1'b1);

    // random phases across base extremes and idle mixes
    run_phase(32'hFFFF_FFFF, 0, 0, 100);
    run_phase(32'($urandom), 81, 0, 100);
    run_phase(32'h0000_0000, 0, 81, 100);
    run_phase(32'($urandom), 27, 27, 100);

    drain();
    if (fail_count == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
